>>> rtl/core/nrn_pkg.sv
package nrn_pkg;

    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int DIVQ_W    = VAL_W + FRAC_W;
    localparam int DCNT_W    = 6;

    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIVQ_W);
    localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_W;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_MAX_TRIES = 2'd1;
    localparam logic [1:0] CFG_ZERO_TOL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] radicand;
        logic [4:0]         degree;
    } t_in;

    typedef struct packed {
        logic signed [31:0] root_value;
        logic               error;
    } t_out;

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] val;
    } t_satv;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_POW_INIT,
        CMD_MUL_V,
        CMD_V_UPD,
        CMD_SUB_P,
        CMD_MUL_M,
        CMD_M_PACK,
        CMD_SET_ERR,
        CMD_MUL_T,
        CMD_T_PACK,
        CMD_SUB_B,
        CMD_NEG_B,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_DIV_END,
        CMD_OUT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRY,
        S_POW_INIT,
        S_POW_LOOP,
        S_V_UPD,
        S_TEST,
        S_M_PACK,
        S_M_CHECK,
        S_T_PACK,
        S_SUB_B,
        S_NEG_B,
        S_DIV_START,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic tries_zero;
        logic pow_done;
        logic tol_ok;
        logic m_zero;
        logic div_done;
        logic out_busy;
    } t_stat;

    function automatic logic [VAL_W-1:0] f_mag(input logic signed [VAL_W-1:0] a);
        return a[VAL_W-1] ? VAL_W'(-a) : a;
    endfunction

    function automatic t_satv f_pack(input logic neg, input logic [63:0] u);
        logic [63:0] lim;
        t_satv r;
        lim = neg ? 64'(VAL_MAX) + 64'd1 : 64'(VAL_MAX);
        if (u > lim) begin
            r.sat = 1'b1;
            r.val = neg ? VAL_MIN : VAL_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = neg ? VAL_W'(-u[VAL_W-1:0]) : u[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic t_satv f_sub(input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        t_satv r;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (d[VAL_W] != d[VAL_W-1]) begin
            r.sat = 1'b1;
            r.val = d[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = d[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/nrn_ctrl.sv
module nrn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nrn_pkg::t_stat i_stat,
    output nrn_pkg::t_cmd  o_cmd
);

    nrn_pkg::t_state r_state;
    nrn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nrn_pkg::S_IDLE: begin
                if (i_in_valid) n_state = nrn_pkg::S_TRY;
            end
            nrn_pkg::S_TRY: begin
                n_state = i_stat.tries_zero ? nrn_pkg::S_OUT : nrn_pkg::S_POW_INIT;
            end
            nrn_pkg::S_POW_INIT: n_state = nrn_pkg::S_POW_LOOP;
            nrn_pkg::S_POW_LOOP: begin
                n_state = i_stat.pow_done ? nrn_pkg::S_TEST : nrn_pkg::S_V_UPD;
            end
            nrn_pkg::S_V_UPD: n_state = nrn_pkg::S_POW_LOOP;
            nrn_pkg::S_TEST: begin
                n_state = i_stat.tol_ok ? nrn_pkg::S_OUT : nrn_pkg::S_M_PACK;
            end
            nrn_pkg::S_M_PACK: n_state = nrn_pkg::S_M_CHECK;
            nrn_pkg::S_M_CHECK: begin
                n_state = i_stat.m_zero ? nrn_pkg::S_OUT : nrn_pkg::S_T_PACK;
            end
            nrn_pkg::S_T_PACK: n_state = nrn_pkg::S_SUB_B;
            nrn_pkg::S_SUB_B: n_state = nrn_pkg::S_NEG_B;
            nrn_pkg::S_NEG_B: n_state = nrn_pkg::S_DIV_START;
            nrn_pkg::S_DIV_START: n_state = nrn_pkg::S_DIV;
            nrn_pkg::S_DIV: begin
                if (i_stat.div_done) n_state = nrn_pkg::S_TRY;
            end
            nrn_pkg::S_OUT: begin
                if (!i_stat.out_busy) n_state = nrn_pkg::S_IDLE;
            end
            default: n_state = nrn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = nrn_pkg::CMD_NONE;
        o_in_stall = (r_state != nrn_pkg::S_IDLE);
        unique case (r_state)
            nrn_pkg::S_IDLE: begin
                if (i_in_valid) o_cmd = nrn_pkg::CMD_LOAD;
            end
            nrn_pkg::S_TRY: begin
                if (!i_stat.tries_zero) o_cmd = nrn_pkg::CMD_POW_INIT;
            end
            nrn_pkg::S_POW_INIT: o_cmd = nrn_pkg::CMD_NONE;
            nrn_pkg::S_POW_LOOP: begin
                o_cmd = i_stat.pow_done ? nrn_pkg::CMD_SUB_P : nrn_pkg::CMD_MUL_V;
            end
            nrn_pkg::S_V_UPD: o_cmd = nrn_pkg::CMD_V_UPD;
            nrn_pkg::S_TEST: begin
                if (!i_stat.tol_ok) o_cmd = nrn_pkg::CMD_MUL_M;
            end
            nrn_pkg::S_M_PACK: o_cmd = nrn_pkg::CMD_M_PACK;
            nrn_pkg::S_M_CHECK: begin
                o_cmd = i_stat.m_zero ? nrn_pkg::CMD_SET_ERR : nrn_pkg::CMD_MUL_T;
            end
            nrn_pkg::S_T_PACK: o_cmd = nrn_pkg::CMD_T_PACK;
            nrn_pkg::S_SUB_B: o_cmd = nrn_pkg::CMD_SUB_B;
            nrn_pkg::S_NEG_B: o_cmd = nrn_pkg::CMD_NEG_B;
            nrn_pkg::S_DIV_START: o_cmd = nrn_pkg::CMD_DIV_START;
            nrn_pkg::S_DIV: begin
                o_cmd = i_stat.div_done ? nrn_pkg::CMD_DIV_END : nrn_pkg::CMD_DIV_STEP;
            end
            nrn_pkg::S_OUT: begin
                if (!i_stat.out_busy) o_cmd = nrn_pkg::CMD_OUT;
            end
            default: o_cmd = nrn_pkg::CMD_NONE;
        endcase
    end

endmodule

>>> rtl/core/nrn_dp.sv
module nrn_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nrn_pkg::t_cmd  i_cmd,
    output nrn_pkg::t_stat o_stat,
    input  nrn_pkg::t_in   i_in_data,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output nrn_pkg::t_out  o_out_data
);

    localparam int VW = nrn_pkg::VAL_W;

    logic [30:0] r_tol;
    logic [7:0]  r_maxt;
    logic [15:0] r_zt;

    logic signed [VW-1:0] r_rad, r_g, r_v, r_pm1, r_p, r_m, r_b;
    logic [4:0]           r_deg, r_cnt;
    logic [7:0]           r_tries;
    logic                 r_err;
    logic [63:0]          r_prod;
    logic                 r_pneg;
    logic [nrn_pkg::DIVQ_W-1:0] r_dq;
    logic [VW-1:0]              r_rem;
    logic [nrn_pkg::DCNT_W-1:0] r_dcnt;
    logic                       r_dneg;
    logic                       r_ov;
    nrn_pkg::t_out              r_out;

    logic signed [VW-1:0] mul_a, mul_b;
    logic [63:0]          prod_c;
    logic [63:0]          prod_sh;
    nrn_pkg::t_satv       pk, sb_p, sb_b;
    logic [VW:0]          rad_h, rem_sh;
    logic [VW:0]          rem_sub;

    always_comb begin
        mul_a = r_v;
        mul_b = r_g;
        unique case (i_cmd)
            nrn_pkg::CMD_MUL_M: begin
                mul_a = r_pm1;
                mul_b = VW'(r_deg);
            end
            nrn_pkg::CMD_MUL_T: begin
                mul_a = r_m;
                mul_b = r_g;
            end
            default: begin
                mul_a = r_v;
                mul_b = r_g;
            end
        endcase
    end

    assign prod_c  = 64'(nrn_pkg::f_mag(mul_a)) * 64'(nrn_pkg::f_mag(mul_b));
    assign prod_sh = (i_cmd == nrn_pkg::CMD_M_PACK) ? r_prod : (r_prod >> nrn_pkg::FRAC_W);
    assign pk      = nrn_pkg::f_pack(r_pneg, prod_sh);
    assign sb_p    = nrn_pkg::f_sub(r_v, r_rad);
    assign sb_b    = nrn_pkg::f_sub(r_p, r_b);
    assign rad_h   = {i_in_data.radicand[VW-1], i_in_data.radicand}
                     + (VW+1)'(i_in_data.radicand[VW-1]);
    assign rem_sh  = {r_rem, r_dq[nrn_pkg::DIVQ_W-1]};
    assign rem_sub = rem_sh - {1'b0, nrn_pkg::f_mag(r_m)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= 31'd66;
            r_maxt <= 8'd100;
            r_zt   <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nrn_pkg::CFG_TOLERANCE: r_tol  <= i_cfg_data[30:0];
                nrn_pkg::CFG_MAX_TRIES: r_maxt <= i_cfg_data[7:0];
                nrn_pkg::CFG_ZERO_TOL:  r_zt   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd == nrn_pkg::CMD_OUT) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            nrn_pkg::CMD_LOAD: begin
                r_rad   <= i_in_data.radicand;
                r_deg   <= i_in_data.degree;
                r_g     <= rad_h[VW:1];
                r_err   <= 1'b0;
                r_tries <= r_maxt;
            end
            nrn_pkg::CMD_POW_INIT: begin
                r_tries <= r_tries - 8'd1;
                if (r_deg != 5'd0 && nrn_pkg::f_mag(r_g) <= VW'(r_zt)) begin
                    r_v   <= '0;
                    r_pm1 <= (r_deg == 5'd1) ? nrn_pkg::VAL_ONE : '0;
                    r_cnt <= 5'd0;
                end else begin
                    r_v   <= nrn_pkg::VAL_ONE;
                    r_pm1 <= nrn_pkg::VAL_ONE;
                    r_cnt <= r_deg;
                end
            end
            nrn_pkg::CMD_MUL_V, nrn_pkg::CMD_MUL_M, nrn_pkg::CMD_MUL_T: begin
                r_prod <= prod_c;
                r_pneg <= mul_a[VW-1] ^ mul_b[VW-1];
                if (i_cmd == nrn_pkg::CMD_MUL_V) r_pm1 <= r_v;
            end
            nrn_pkg::CMD_V_UPD: begin
                r_v   <= pk.val;
                r_err <= r_err | pk.sat;
                r_cnt <= r_cnt - 5'd1;
            end
            nrn_pkg::CMD_SUB_P: begin
                r_p   <= sb_p.val;
                r_err <= r_err | sb_p.sat;
            end
            nrn_pkg::CMD_M_PACK: begin
                r_m   <= pk.val;
                r_err <= r_err | pk.sat;
            end
            nrn_pkg::CMD_SET_ERR: r_err <= 1'b1;
            nrn_pkg::CMD_T_PACK: begin
                r_b   <= pk.val;
                r_err <= r_err | pk.sat;
            end
            nrn_pkg::CMD_SUB_B: begin
                r_b   <= sb_b.val;
                r_err <= r_err | sb_b.sat;
            end
            nrn_pkg::CMD_NEG_B: begin
                if (r_b == nrn_pkg::VAL_MIN) begin
                    r_b   <= nrn_pkg::VAL_MAX;
                    r_err <= 1'b1;
                end else begin
                    r_b <= VW'(-r_b);
                end
            end
            nrn_pkg::CMD_DIV_START: begin
                r_dq   <= {nrn_pkg::f_mag(r_b), {nrn_pkg::FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_dcnt <= nrn_pkg::DIV_STEPS;
                r_dneg <= r_b[VW-1] ^ r_m[VW-1];
            end
            nrn_pkg::CMD_DIV_STEP: begin
                r_dcnt <= r_dcnt - nrn_pkg::DCNT_W'(1);
                if (!rem_sub[VW]) begin
                    r_rem <= rem_sub[VW-1:0];
                    r_dq  <= {r_dq[nrn_pkg::DIVQ_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[VW-1:0];
                    r_dq  <= {r_dq[nrn_pkg::DIVQ_W-2:0], 1'b0};
                end
            end
            nrn_pkg::CMD_DIV_END: begin
                r_g   <= nrn_pkg::f_pack(r_dneg, 64'(r_dq)).val;
                r_err <= r_err | nrn_pkg::f_pack(r_dneg, 64'(r_dq)).sat;
            end
            nrn_pkg::CMD_OUT: begin
                r_out.root_value <= r_g;
                r_out.error      <= r_err;
            end
            default: ;
        endcase
    end

    assign o_stat.tries_zero = (r_tries == 8'd0);
    assign o_stat.pow_done   = (r_cnt == 5'd0);
    assign o_stat.tol_ok     = ({1'b0, nrn_pkg::f_mag(r_p)} <= {2'b0, r_tol});
    assign o_stat.m_zero     = (r_m == '0);
    assign o_stat.div_done   = (r_dcnt == '0);
    assign o_stat.out_busy   = r_ov & i_out_stall;

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_load_clears_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nrn_pkg::CMD_LOAD) |=> !r_err)
        else $error("error flag not cleared on a new request");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nrn_pkg::CMD_DIV_START) |-> (r_m != '0))
        else $error("division started with a zero slope");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nrn_pkg::CMD_OUT) |-> !(r_ov && i_out_stall))
        else $error("result overwritten while stalled");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nrn_pkg::CMD_DIV_START) |=> (r_dcnt == nrn_pkg::DIV_STEPS))
        else $error("divider step count not loaded");

endmodule

>>> rtl/core/nth_root_newton.sv
// Each Newton try runs the power loop (per multiply, a multiply state and an
// update state) plus a 48-step bit-serial divider.
// Throughput: one request at a time; the next is taken once the result is in the
// output register, even while that result is still stalled.
// Reset is synchronous and active low; datapath registers have no reset value.
module nth_root_newton (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nrn_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nrn_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    nrn_pkg::t_cmd  cmd;
    nrn_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    nrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nrn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/sv/tb_nth_root_newton.sv
module tb_nth_root_newton;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int LIMIT = 30000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    nrn_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    nrn_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = nrn_pkg::CFG_TOLERANCE;
    logic [31:0] i_cfg_data = '0;

    nth_root_newton i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    nrn_pkg::t_in pending_reqs[$];
    nrn_pkg::t_out expected_roots[$];
    int fail_count = 0;
    int req_count = 0;
    int root_count = 0;
    int err_count = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    logic hold_off = 1'b0;

    longint unsigned tol_reg = 66;
    longint unsigned tries_reg = 100;
    longint unsigned ztol_reg = 1;
    bit sat_seen;

    function automatic longint unsigned magn(longint a);
        return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    function automatic longint sat_pack(bit neg, logic [63:0] u, bit over);
        logic [63:0] lim;
        lim = neg ? 64'(MAXV) + 64'd1 : 64'(MAXV);
        if (over || u > lim) begin
            sat_seen = 1'b1;
            u = lim;
        end
        return neg ? -longint'(u) : longint'(u);
    endfunction

    function automatic longint q_mul(longint a, longint b, int shift);
        logic [127:0] pr;
        pr = {64'd0, magn(a)} * {64'd0, magn(b)};
        pr = pr >> shift;
        return sat_pack((a < 0) != (b < 0), pr[63:0], pr[127:64] != 0);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] num, quo;
        num = {64'd0, magn(a)} << nrn_pkg::FRAC_W;
        quo = num / {64'd0, magn(b)};
        return sat_pack((a < 0) != (b < 0), quo[63:0], quo[127:64] != 0);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        longint d;
        d = a - b;
        if (d > MAXV) begin sat_seen = 1'b1; return MAXV; end
        if (d < MINV) begin sat_seen = 1'b1; return MINV; end
        return d;
    endfunction

    function automatic longint q_neg(longint a);
        if (a == MINV) begin
            sat_seen = 1'b1;
            return MAXV;
        end
        return -a;
    endfunction

    function automatic longint q_pow(longint base, int e);
        longint v;
        if (e != 0 && magn(base) <= ztol_reg)
            return 0;
        v = longint'(1) << nrn_pkg::FRAC_W;
        repeat (e) v = q_mul(v, base, nrn_pkg::FRAC_W);
        return v;
    endfunction

    function automatic nrn_pkg::t_out root_predict(nrn_pkg::t_in req);
        longint rad, g, p, m, b;
        longint unsigned tries;
        int deg;
        nrn_pkg::t_out r;
        rad = longint'(req.radicand);
        deg = int'(req.degree);
        tries = tries_reg;
        sat_seen = 1'b0;
        g = rad / 2;
        while (tries != 0) begin
            tries--;
            p = q_sub(q_pow(g, deg), rad);
            if (magn(p) <= tol_reg)
                break;
            m = deg == 0 ? 0 : q_mul(q_pow(g, deg - 1), longint'(deg), 0);
            if (m == 0) begin
                sat_seen = 1'b1;
                break;
            end
            b = q_sub(p, q_mul(m, g, nrn_pkg::FRAC_W));
            g = q_div(q_neg(b), m);
        end
        r.root_value = g[31:0];
        r.error = sat_seen;
        return r;
    endfunction

    int send_gap = 0;

    always @(posedge i_clk) begin
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_roots.push_back(root_predict(i_in_data));
                void'(pending_reqs.pop_front());
                req_count++;
                offering = 1'b0;
                send_gap = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    offering = 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_in_data <= pending_reqs[0];
                    offering = 1'b1;
                end
            end
            i_in_valid <= offering;
        end
    end

    int recv_gap = 0;

    always @(posedge i_clk) begin
        nrn_pkg::t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                root_count++;
                if (o_out_data.error) err_count++;
                if (expected_roots.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result root_value=%h error=%b", $time,
                             o_out_data.root_value, o_out_data.error);
                end else begin
                    want = expected_roots.pop_front();
                    if (o_out_data.root_value !== want.root_value) begin
                        fail_count++;
                        $display("%0t: root_value expected %h actual %h", $time,
                                 want.root_value, o_out_data.root_value);
                    end
                    if (o_out_data.error !== want.error) begin
                        fail_count++;
                        $display("%0t: error expected %b actual %b", $time,
                                 want.error, o_out_data.error);
                    end
                end
                recv_gap = idle_on ? $urandom_range(0, 8) : 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            i_out_stall <= hold_off || recv_gap > 0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            nrn_pkg::CFG_TOLERANCE: tol_reg = v & 32'h7FFF_FFFF;
            nrn_pkg::CFG_MAX_TRIES: tries_reg = v & 32'hFF;
            nrn_pkg::CFG_ZERO_TOL:  ztol_reg = v & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic add_req(logic [31:0] rad, logic [4:0] deg);
        nrn_pkg::t_in r;
        r.radicand = rad;
        r.degree = deg;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_roots.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        logic [31:0] rad;
        logic [4:0] deg;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: rad = $urandom;
                1: rad = $urandom_range(0, 32'h00FF_FFFF);
                2: rad = -$urandom_range(0, 32'h0010_0000);
                default: rad = $urandom_range(0, 32'h0004_0000);
            endcase
            deg = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
            add_req(rad, deg);
        end
    endtask

    task automatic set_all(logic [31:0] tol, logic [31:0] tries, logic [31:0] ztol);
        cfg_write(nrn_pkg::CFG_TOLERANCE, tol);
        cfg_write(nrn_pkg::CFG_MAX_TRIES, tries);
        cfg_write(nrn_pkg::CFG_ZERO_TOL, ztol);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_req(32'h0000_0000, 5'd2);
        add_req(32'h0001_0000, 5'd1);
        add_req(32'h0001_0000, 5'd2);
        add_req(32'h0004_0000, 5'd2);
        add_req(32'h001B_0000, 5'd3);
        add_req(32'h7FFF_FFFF, 5'd2);
        add_req(32'h7FFF_FFFF, 5'd16);
        add_req(32'h8000_0000, 5'd1);
        add_req(32'h8000_0000, 5'd2);
        add_req(32'h8000_0000, 5'd3);
        add_req(32'hFFFF_FFFF, 5'd3);
        add_req(32'hFFF8_0000, 5'd3);
        add_req(32'h0005_0000, 5'd0);
        add_req(32'h0001_0000, 5'd0);
        add_req(32'h0002_0000, 5'd31);
        add_req(32'h0000_0001, 5'd5);
        add_req(32'h0000_0002, 5'd2);
        add_req(32'h0000_0003, 5'd2);
        add_req(32'h0010_0000, 5'd4);
        add_req(32'h0100_0000, 5'd8);
        drain();

        set_all(32'd0, 32'd255, 32'd0);
        repeat (12) add_req($urandom_range(0, 32'h0100_0000), 5'($urandom_range(1, 3)));
        drain();

        set_all(32'h7FFF_FFFF, 32'd1, 32'd65535);
        add_random(30);
        drain();

        set_all(32'hFFFF_FFFF, 32'd0, 32'd1);
        add_random(10);
        drain();

        hold_off <= 1'b1;
        set_all(32'd66, 32'd8, 32'd1);
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        add_random(40);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            @(negedge i_clk);
            idle_on = ph % 3 != 2;
            set_all(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 200),
                    $urandom_range(1, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 80));
            add_random(55);
            drain();
        end

        $display("Covered %0d requests and %0d results (%0d with error) over", req_count,
                 root_count, err_count);
        $display("default, extreme and random tolerance, try-limit and zero-bound settings.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> nth_root_newton.f
rtl/core/nrn_pkg.sv
rtl/core/nrn_ctrl.sv
rtl/core/nrn_dp.sv
rtl/core/nth_root_newton.sv
tb/sv/tb_nth_root_newton.sv
